/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the stable priority task queue.
// No dependencies; compiled first.
`default_nettype none

package spq_pkg;

  localparam int FIELD_TAG_W = 16;
  localparam int RESULT_CAP  = 16;   // most results one list transaction returns
  localparam int COUNT_SAT   = 31;   // count field saturates here

  typedef logic [2:0]  op_field_t;
  typedef logic [3:0]  prio_t;
  typedef logic [15:0] tag_field_t;
  typedef logic [4:0]  count_t;

  localparam prio_t PRIO_MIN = 4'd1;
  localparam prio_t PRIO_MAX = 4'd10;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_POP      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_POSITION = 3'd3,
    OP_LIST     = 3'd4,
    OP_CHANGE   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_BADPRIO  = 3'd5
  } status_t;

  // Broadcast command to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    prio_t    key_prio;
  } cell_ctrl_t;

  typedef struct packed {
    logic  valid;
    prio_t prio;
  } cell_meta_t;

  // Compare results a cell reports against the broadcast key
  typedef struct packed {
    logic hit;   // holds the key tag
    logic ge;    // priority >= key priority
    logic gt;    // priority >  key priority
  } cell_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/spq_channels.sv */
// Valid/ready channel interfaces for the request and result streams.
// Depends on spq_pkg.
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;

  logic       valid;
  logic       ready;
  op_field_t  op;
  prio_t      priority_req;
  tag_field_t tag;

  modport source (output valid, op, priority_req, tag, input ready);
  modport sink   (input valid, op, priority_req, tag, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  tag_field_t result_tag;
  prio_t      result_priority;
  count_t     count;
  logic       last;

  modport source (output valid, status, result_tag, result_priority, count, last,
                  input ready);
  modport sink   (input valid, status, result_tag, result_priority, count, last,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// One slot of the sorted chain: holds valid, priority and tag, compares
// against the broadcast key and shifts to/from its neighbours. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
  parameter int TAG_W = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire spq_pkg::cell_ctrl_t   ctrl,
  input  wire logic [TAG_W-1:0]      key_tag,
  input  wire spq_pkg::cell_meta_t   left_meta,
  input  wire logic [TAG_W-1:0]      left_tag,
  input  wire logic                  left_ge,
  input  wire spq_pkg::cell_meta_t   right_meta,
  input  wire logic [TAG_W-1:0]      right_tag,
  input  wire logic                  del_sel,
  output spq_pkg::cell_meta_t        meta,
  output logic [TAG_W-1:0]           tag,
  output spq_pkg::cell_flags_t       flags
);
  import spq_pkg::*;

  logic             valid_r, valid_nxt;
  prio_t            prio_r, prio_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  assign flags.hit = valid_r && (tag_r == key_tag);
  assign flags.ge  = valid_r && (prio_r >= ctrl.key_prio);
  assign flags.gt  = valid_r && (prio_r >  ctrl.key_prio);

  assign meta.valid = valid_r;
  assign meta.prio  = prio_r;
  assign tag        = tag_r;

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    tag_nxt   = tag_r;
    case (ctrl.op)
      CELL_INSERT: begin
        // entries ahead of the new one stay; the first behind takes it
        if (!flags.ge) begin
          if (left_ge) begin
            valid_nxt = 1'b1;
            prio_nxt  = ctrl.key_prio;
            tag_nxt   = key_tag;
          end else begin
            valid_nxt = left_meta.valid;
            prio_nxt  = left_meta.prio;
            tag_nxt   = left_tag;
          end
        end
      end
      CELL_DELETE: begin
        if (del_sel) begin
          valid_nxt = right_meta.valid;
          prio_nxt  = right_meta.prio;
          tag_nxt   = right_tag;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/stable_priority_task_queue.sv */
// Stable priority task queue: top level with controller and chain of slots.
// Depends on spq_pkg, spq_channels (spq_in_if, spq_out_if) and spq_cell.
//
// Usage:
//  - in_ch carries one request per transaction: op, priority_req, tag.
//    out_ch carries results: status, result_tag, result_priority, count, last.
//    last marks the final result of a request.
//  - Tasks sit in a row of QUEUE_DEPTH slots, highest priority at slot 0 and
//    oldest first within a priority. Every slot compares itself with the
//    request key at once; insert and delete shift the row by one place.
//  - Timing: a request is latched on acceptance and acted on in S_APPLY once
//    the output register is free; its result then goes to the output register.
//    Change priority makes a delete pass in S_APPLY, then an insert pass in
//    S_INS. A list of n matching tasks (n >= 2) gives min(n,16) results, one
//    per cycle while the receiver takes them, walked in S_LIST. Ops 6 and 7
//    are taken and dropped.
//  - in_ch.ready is high only while the controller is idle; a new request
//    can be accepted while the last result still waits in the output
//    register. A stalled receiver holds the controller before its next
//    write to the output register; nothing is lost.
//  - Reset (synchronous, active low) empties the queue at once.
`default_nettype none

module stable_priority_task_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire       clk,
  input  wire       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int TAG_W = (TAG_BITS < FIELD_TAG_W) ? TAG_BITS : FIELD_TAG_W;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_APPLY = 4'b0010,
    S_INS   = 4'b0100,
    S_LIST  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // latched request key
  op_t              op_r, op_nxt;
  prio_t            pr_r, pr_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  // list walk
  logic [IDX_W-1:0] idx_r, idx_nxt;
  count_t           rem_r, rem_nxt;
  count_t           lcnt_r, lcnt_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  tag_field_t out_tag_r, out_tag_nxt;
  prio_t      out_prio_r, out_prio_nxt;
  count_t     out_count_r, out_count_nxt;
  logic       out_last_r, out_last_nxt;

  // chain wiring
  cell_ctrl_t       cell_ctrl;
  cell_meta_t       meta [QUEUE_DEPTH];
  logic [TAG_W-1:0] tags [QUEUE_DEPTH];
  cell_flags_t      flags [QUEUE_DEPTH];
  cell_meta_t       lmeta [QUEUE_DEPTH];
  logic [TAG_W-1:0] ltag [QUEUE_DEPTH];
  logic             lge [QUEUE_DEPTH];
  cell_meta_t       rmeta [QUEUE_DEPTH];
  logic [TAG_W-1:0] rtag [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] hit_v, ge_v, gt_v, valid_v, del_sel_v;

  logic             accept, out_free;
  logic             any_hit, empty, full, prio_ok;
  logic             del_all, del_tag;
  cell_op_t         cell_op;
  logic [IDX_W-1:0] hit_pos;
  logic [CNT_W-1:0] cnt_ge, cnt_gt, n_match;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // ---------------------------------------------------------------- chain
  assign cell_ctrl.op       = cell_op;
  assign cell_ctrl.key_prio = pr_r;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lmeta[i] = '0;
      assign ltag[i]  = '0;
      assign lge[i]   = 1'b1;   // new entry goes to the head if nothing ranks ahead
    end else begin : g_left
      assign lmeta[i] = meta[i-1];
      assign ltag[i]  = tags[i-1];
      assign lge[i]   = flags[i-1].ge;
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rmeta[i] = '0;
      assign rtag[i]  = '0;
    end else begin : g_right
      assign rmeta[i] = meta[i+1];
      assign rtag[i]  = tags[i+1];
    end

    assign hit_v[i]   = flags[i].hit;
    assign ge_v[i]    = flags[i].ge;
    assign gt_v[i]    = flags[i].gt;
    assign valid_v[i] = meta[i].valid;

    spq_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .key_tag    (tag_r),
      .left_meta  (lmeta[i]),
      .left_tag   (ltag[i]),
      .left_ge    (lge[i]),
      .right_meta (rmeta[i]),
      .right_tag  (rtag[i]),
      .del_sel    (del_sel_v[i]),
      .meta       (meta[i]),
      .tag        (tags[i]),
      .flags      (flags[i])
    );
  end

  // ------------------------------------------------------- status of chain
  assign any_hit = |hit_v;
  assign empty   = !valid_v[0];
  assign full    = valid_v[QUEUE_DEPTH-1];
  assign prio_ok = (pr_r >= PRIO_MIN) && (pr_r <= PRIO_MAX);

  // tags are unique, so the hit vector is one-hot: OR the indexes
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (hit_v[i]) hit_pos |= IDX_W'(i);
    end
  end

  // ge/gt are thermometer codes (row is sorted); count = position of the edge
  always_comb begin
    cnt_ge = '0;
    cnt_gt = '0;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (ge_v[i] && !ge_v[i+1]) cnt_ge |= CNT_W'(i + 1);
      if (gt_v[i] && !gt_v[i+1]) cnt_gt |= CNT_W'(i + 1);
    end
    if (ge_v[QUEUE_DEPTH-1]) cnt_ge = CNT_W'(QUEUE_DEPTH);
    if (gt_v[QUEUE_DEPTH-1]) cnt_gt = CNT_W'(QUEUE_DEPTH);
  end

  assign n_match = cnt_ge - cnt_gt;

  // delete: every slot from the hit onwards (or all, for pop) takes its right neighbour
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      del_sel_v[i] = del_all || (del_tag && (IDX_W'(i) >= hit_pos));
    end
  end

  // ------------------------------------------------------------ controller
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pr_nxt         = pr_r;
    tag_nxt        = tag_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    lcnt_nxt       = lcnt_r;
    cell_op        = CELL_HOLD;
    del_all        = 1'b0;
    del_tag        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_prio_nxt   = out_prio_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = op_t'(in_ch.op);
          pr_nxt  = in_ch.priority_req;
          tag_nxt = in_ch.tag[TAG_W-1:0];
          case (op_t'(in_ch.op)) inside
            OP_INSERT, OP_POP, OP_REMOVE, OP_POSITION, OP_LIST, OP_CHANGE:
              state_nxt = S_APPLY;
            default: state_nxt = S_IDLE;   // undefined op: dropped
          endcase
        end
      end

      S_APPLY: begin
        if (out_free) begin
          // single-result default: zeros, last set
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_tag_nxt    = '0;
          out_prio_nxt   = '0;
          out_count_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;

          if (op_r == OP_INSERT) begin
            if (!prio_ok)     out_status_nxt = ST_BADPRIO;
            else if (any_hit) out_status_nxt = ST_DUP;
            else if (full)    out_status_nxt = ST_FULL;
            else              cell_op        = CELL_INSERT;
          end else if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            case (op_r)
              OP_POP: begin
                out_tag_nxt  = FIELD_TAG_W'(tags[0]);
                out_prio_nxt = meta[0].prio;
                cell_op      = CELL_DELETE;
                del_all      = 1'b1;
              end
              OP_LIST: begin
                if (!prio_ok) begin
                  out_status_nxt = ST_BADPRIO;
                end else if (n_match >= CNT_W'(2)) begin
                  // several results: walk the matching run
                  out_valid_nxt = out_valid_r && !out_ch.ready;
                  idx_nxt       = IDX_W'(cnt_gt);
                  rem_nxt       = (int'(n_match) > RESULT_CAP) ? count_t'(RESULT_CAP)
                                                               : count_t'(n_match);
                  lcnt_nxt      = (int'(n_match) > COUNT_SAT) ? count_t'(COUNT_SAT)
                                                              : count_t'(n_match);
                  state_nxt     = S_LIST;
                end
              end
              OP_REMOVE: begin
                if (!any_hit) begin
                  out_status_nxt = ST_NOTFOUND;
                end else begin
                  cell_op = CELL_DELETE;
                  del_tag = 1'b1;
                end
              end
              OP_POSITION: begin
                if (!any_hit) begin
                  out_status_nxt = ST_NOTFOUND;
                end else begin
                  out_count_nxt = (int'(hit_pos) > COUNT_SAT) ? count_t'(COUNT_SAT)
                                                              : count_t'(hit_pos);
                end
              end
              OP_CHANGE: begin
                if (!any_hit) begin
                  out_status_nxt = ST_NOTFOUND;
                end else if (!prio_ok) begin
                  out_status_nxt = ST_BADPRIO;
                end else begin
                  // delete now, reinsert at the back of the new group next cycle
                  cell_op   = CELL_DELETE;
                  del_tag   = 1'b1;
                  state_nxt = S_INS;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_INS: begin
        cell_op   = CELL_INSERT;
        state_nxt = S_IDLE;
      end

      S_LIST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_tag_nxt    = FIELD_TAG_W'(tags[idx_r]);
          out_prio_nxt   = pr_r;
          out_count_nxt  = lcnt_r;
          out_last_nxt   = (rem_r == count_t'(1));
          idx_nxt        = idx_r + IDX_W'(1);
          rem_nxt        = rem_r - count_t'(1);
          if (rem_r == count_t'(1)) state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pr_r         <= pr_nxt;
    tag_r        <= tag_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    lcnt_r       <= lcnt_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_prio_r   <= out_prio_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.result_tag      = out_tag_r;
  assign out_ch.result_priority = out_prio_r;
  assign out_ch.count           = out_count_r;
  assign out_ch.last            = out_last_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stable_priority_task_queue: directed and random requests,
// results checked against an in-bench model of the sorted task queue.
// Depends on spq_pkg, spq_channels and the block itself.

import spq_pkg::*;

typedef struct {
  status_t    status;
  tag_field_t tag;
  prio_t      prio;
  count_t     count;
  logic       last;
} task_result_t;

class queue_scoreboard #(int DEPTH = 16);
  prio_t        slot_prio[DEPTH];
  tag_field_t   slot_tag[DEPTH];
  int           occupancy;
  task_result_t awaited[$];
  int           errors;

  function new();
    occupancy = 0;
    errors    = 0;
  endfunction

  function int find_tag(tag_field_t tg);
    for (int i = 0; i < occupancy; i++) begin
      if (slot_tag[i] == tg) return i;
    end
    return -1;
  endfunction

  function void delete_at(int pos);
    for (int i = pos; i + 1 < occupancy; i++) begin
      slot_tag[i]  = slot_tag[i + 1];
      slot_prio[i] = slot_prio[i + 1];
    end
    occupancy--;
  endfunction

  // behind every task of equal or higher priority
  function void insert_sorted(prio_t pr, tag_field_t tg);
    int pos;
    pos = 0;
    while (pos < occupancy && slot_prio[pos] >= pr) pos++;
    for (int i = occupancy; i > pos; i--) begin
      slot_tag[i]  = slot_tag[i - 1];
      slot_prio[i] = slot_prio[i - 1];
    end
    slot_tag[pos]  = tg;
    slot_prio[pos] = pr;
    occupancy++;
  endfunction

  function void await_result(status_t st, tag_field_t tg, prio_t pr, count_t cnt, logic lst);
    task_result_t r;
    r.status = st;
    r.tag    = tg;
    r.prio   = pr;
    r.count  = cnt;
    r.last   = lst;
    awaited.push_back(r);
  endfunction

  // Update the queue for one accepted request and queue up what it should return
  function void note_request(op_field_t op, prio_t pr, tag_field_t tg);
    bit     prio_ok;
    int     pos;
    int     n_same;
    int     shown;
    int     emit;
    count_t cnt;
    prio_ok = (pr >= PRIO_MIN) && (pr <= PRIO_MAX);
    if (op > OP_CHANGE) return;
    if (op == OP_INSERT) begin
      if (!prio_ok) await_result(ST_BADPRIO, '0, '0, '0, 1'b1);
      else if (find_tag(tg) >= 0) await_result(ST_DUP, '0, '0, '0, 1'b1);
      else if (occupancy >= DEPTH) await_result(ST_FULL, '0, '0, '0, 1'b1);
      else begin
        insert_sorted(pr, tg);
        await_result(ST_OK, '0, '0, '0, 1'b1);
      end
      return;
    end
    if (occupancy == 0) begin
      await_result(ST_EMPTY, '0, '0, '0, 1'b1);
      return;
    end
    case (op)
      OP_POP: begin
        await_result(ST_OK, slot_tag[0], slot_prio[0], '0, 1'b1);
        delete_at(0);
      end
      OP_LIST: begin
        if (!prio_ok) begin
          await_result(ST_BADPRIO, '0, '0, '0, 1'b1);
        end else begin
          n_same = 0;
          for (int i = 0; i < occupancy; i++) if (slot_prio[i] == pr) n_same++;
          if (n_same < 2) begin
            await_result(ST_OK, '0, '0, '0, 1'b1);
          end else begin
            cnt   = count_t'((n_same > COUNT_SAT) ? COUNT_SAT : n_same);
            emit  = (n_same > RESULT_CAP) ? RESULT_CAP : n_same;
            shown = 0;
            for (int i = 0; i < occupancy && shown < emit; i++) begin
              if (slot_prio[i] == pr) begin
                await_result(ST_OK, slot_tag[i], pr, cnt, logic'(shown + 1 == emit));
                shown++;
              end
            end
          end
        end
      end
      default: begin
        pos = find_tag(tg);
        if (pos < 0) begin
          await_result(ST_NOTFOUND, '0, '0, '0, 1'b1);
        end else if (op == OP_REMOVE) begin
          delete_at(pos);
          await_result(ST_OK, '0, '0, '0, 1'b1);
        end else if (op == OP_POSITION) begin
          await_result(ST_OK, '0, '0, count_t'((pos > COUNT_SAT) ? COUNT_SAT : pos), 1'b1);
        end else if (!prio_ok) begin
          await_result(ST_BADPRIO, '0, '0, '0, 1'b1);
        end else begin
          delete_at(pos);
          insert_sorted(pr, tg);
          await_result(ST_OK, '0, '0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  function void check_result(task_result_t got);
    task_result_t want;
    if (awaited.size() == 0) begin
      $error("unexpected result: status %0d tag %h prio %0d count %0d last %0b",
             got.status, got.tag, got.prio, got.count, got.last);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.tag !== want.tag) begin
      $error("result_tag: expected %h, actual %h", want.tag, got.tag);
      errors++;
    end
    if (got.prio !== want.prio) begin
      $error("result_priority: expected %0d, actual %0d", want.prio, got.prio);
      errors++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, actual %0d", want.count, got.count);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      errors++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb_top;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int CYCLE_LIMIT = 600000;  // far beyond the slowest legal run
  localparam int TAIL_CYCLES = 40;      // longest list drains in well under this
  localparam int PHASE_ITEMS = 80;
  localparam int POOL_SIZE   = 24;

  // ops 6 and 7 are not decoded; the block takes and drops them
  localparam op_field_t OP_SPARE_6 = 3'd6;
  localparam op_field_t OP_SPARE_7 = 3'd7;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  stable_priority_task_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  queue_scoreboard #(QUEUE_DEPTH) sb;

  int sender_idle_pct;     // chance per cycle that the sender holds off
  int receiver_stall_pct;  // chance per cycle that out_ch.ready is low

  tag_field_t tag_pool[POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or missing result ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Monitor. Results are checked before the request of the same edge is noted,
  // so a stray result can never pair off with a fresh expectation.
  always @(posedge clk) begin
    task_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.tag    = out_ch.result_tag;
        got.prio   = out_ch.result_priority;
        got.count  = out_ch.count;
        got.last   = out_ch.last;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.op, in_ch.priority_req, in_ch.tag);
      end
    end
  end

  // Present one request and hold it until the transaction completes.
  // Idle cycles only ever come before valid rises, never while it is up.
  task automatic send_item(input op_field_t op, input prio_t pr, input tag_field_t tg);
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.priority_req <= pr;
    in_ch.tag          <= tg;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    op_field_t  op;
    prio_t      pr;
    tag_field_t tg;
    int         pick;
    int         insert_weight;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = '0;
    in_ch.priority_req = '0;
    in_ch.tag          = '0;
    out_ch.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    sb                 = new();

    // pool: the sixteen directed tags plus a few random ones, so random
    // traffic hits live tags, duplicates and a full queue often
    for (int i = 0; i < POOL_SIZE; i++) begin
      tag_pool[i] = (i < QUEUE_DEPTH) ? tag_field_t'(i * 16'h1111) : tag_field_t'($urandom);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // every op except insert on an empty queue answers queue empty
    send_item(OP_POP,      PRIO_MIN, 16'h0000);
    send_item(OP_REMOVE,   PRIO_MIN, 16'h0000);
    send_item(OP_POSITION, PRIO_MIN, 16'h0000);
    send_item(OP_LIST,     PRIO_MAX, 16'h0000);
    send_item(OP_CHANGE,   PRIO_MAX, 16'h0000);
    // fill to the brim with one priority, tags 0000 up to FFFF
    for (int i = 0; i < QUEUE_DEPTH; i++) send_item(OP_INSERT, PRIO_MAX, tag_pool[i]);
    send_item(OP_INSERT,   4'd3,     16'h5555);  // duplicate tag
    send_item(OP_INSERT,   PRIO_MIN, 16'h1234);  // queue full
    send_item(OP_INSERT,   4'd11,    16'h1234);  // bad priority wins over full
    send_item(OP_INSERT,   4'd0,     16'h5555);  // bad priority wins over duplicate
    send_item(OP_LIST,     PRIO_MAX, 16'h0000);  // sixteen results, the longest burst
    send_item(OP_LIST,     4'd15,    16'h0000);  // bad priority on list
    send_item(OP_POSITION, PRIO_MIN, 16'hFFFF);  // deepest slot
    send_item(OP_CHANGE,   4'd12,    16'h1234);  // not found wins over bad priority
    send_item(OP_CHANGE,   4'd12,    16'h2222);  // bad priority, queue untouched
    send_item(OP_SPARE_6,  4'd15,    16'hFFFF);
    send_item(OP_SPARE_7,  4'd0,     16'h0000);

    // ---- random part, one idling pattern per phase ----
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
        default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 15) begin
          // noise: any op, any priority, any tag
          op = op_field_t'($urandom_range(0, 7));
          pr = prio_t'($urandom_range(0, 15));
          tg = tag_field_t'($urandom);
        end else begin
          // well formed: inserts lean on occupancy so the queue swings
          // between nearly empty and full
          insert_weight = (sb.occupancy < 6) ? 55 : ((sb.occupancy > 13) ? 25 : 35);
          pick = $urandom_range(99);
          if (pick < insert_weight) op = OP_INSERT;
          else op = op_field_t'((pick - insert_weight) % 5 + 1);
          // a narrow priority band now and then builds groups worth listing
          pr = $urandom_range(1) ? prio_t'($urandom_range(1, 10))
                                 : prio_t'($urandom_range(1, 3));
          tg = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(POOL_SIZE - 1)]
                                         : tag_field_t'($urandom);
        end
        send_item(op, pr, tg);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain, then watch a little longer for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
